>>> rtl/core/tod_pkg.sv
// Shared types, constants and channel update functions for the timed-on /
// delayed-off switch bank. No dependencies.
package tod_pkg;

   localparam int CHANNELS = 4;
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [15:0] STEP       = 16'd10;
   localparam logic [3:0]  WAKE_TICKS = 4'd10;

   typedef logic [CH_W-1:0] idx_type;

   typedef enum logic [2:0] {
      OP_OFF    = 3'd0,
      OP_ON     = 3'd1,
      OP_TOGGLE = 3'd2,
      OP_TIMED  = 3'd3,
      OP_LAMP   = 3'd4,
      OP_TICK   = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_OFF     = 2'd0,
      MODE_ON      = 2'd1,
      MODE_TIMED   = 2'd2,
      MODE_DELAYED = 2'd3
   } mode_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } seq_state_type;

   typedef struct packed {
      mode_type    mode;
      logic        lamp;
      logic [15:0] on_cnt;
      logic [15:0] off_cnt;
      logic        armed;
      logic [3:0]  ticks;
   } chan_state_type;

   typedef struct packed {
      logic           rd_en;
      idx_type        rd_idx;
      logic           wr_en;
      idx_type        wr_idx;
      chan_state_type wr_data;
   } ram_req_type;

   function automatic logic [15:0] drop_ten(input logic [15:0] v);
      return (v >= STEP) ? 16'(v - STEP) : 16'd0;
   endfunction

   function automatic chan_state_type reevaluate(input chan_state_type s, input logic dec);
      chan_state_type r;
      logic [3:0]     nxt;
      logic [15:0]    on;
      logic [15:0]    off;
      r   = s;
      nxt = WAKE_TICKS;
      on  = s.on_cnt;
      off = s.off_cnt;
      unique case (s.mode)
         MODE_ON: begin
            if (on != 16'd0) r.mode = MODE_TIMED;
            else if (off != 16'd0) r.mode = MODE_DELAYED;
         end
         MODE_OFF: begin
            if (on != 16'd0) begin
               r.lamp = 1'b1;
               r.mode = MODE_TIMED;
            end else if (off != 16'd0) begin
               r.mode = MODE_DELAYED;
            end
         end
         MODE_TIMED: begin
            if (dec) on = drop_ten(on);
            r.on_cnt = on;
            if (on == 16'd0) begin
               r.lamp = 1'b0;
               if (off != 16'd0) begin
                  r.mode = MODE_DELAYED;
               end else begin
                  r.mode = MODE_OFF;
                  nxt    = 4'd0;
               end
            end else if (on < STEP) begin
               nxt = on[3:0];
            end
         end
         MODE_DELAYED: begin
            if (dec) off = drop_ten(off);
            r.off_cnt = off;
            if (off == 16'd0) begin
               r.mode = MODE_OFF;
               nxt    = 4'd0;
            end else if (off < STEP) begin
               nxt = off[3:0];
            end
         end
      endcase
      if (nxt != 4'd0) begin
         r.armed = 1'b1;
         r.ticks = nxt;
      end
      return r;
   endfunction

   function automatic chan_state_type cmd_off(input chan_state_type s);
      chan_state_type r;
      r = s;
      priority case (s.mode)
         MODE_ON: begin
            r.mode = MODE_OFF;
            r.lamp = 1'b0;
         end
         MODE_TIMED: begin
            r.on_cnt = 16'd0;
            r.armed  = 1'b0;
            r.ticks  = 4'd0;
            r       = reevaluate(r, 1'b0);
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic chan_state_type cmd_on(input chan_state_type s);
      chan_state_type r;
      r = s;
      priority case (s.mode)
         MODE_OFF: begin
            r.lamp = 1'b1;
            r.mode = MODE_ON;
         end
         MODE_TIMED, MODE_DELAYED: begin
            r.armed   = 1'b0;
            r.ticks   = 4'd0;
            r.on_cnt  = 16'd0;
            r.off_cnt = 16'd0;
            if (s.mode == MODE_DELAYED) r.lamp = 1'b1;
            r.mode = MODE_ON;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic logic cmd_ignored(input chan_state_type s, input opcode_type op,
                                        input logic only_on);
      return (op == OP_TIMED) && only_on && (s.mode != MODE_ON);
   endfunction

   function automatic chan_state_type cmd_update(input chan_state_type s,
                                                 input opcode_type op,
                                                 input logic only_on,
                                                 input logic [15:0] on_req,
                                                 input logic [15:0] off_req,
                                                 input logic lv);
      chan_state_type r;
      r = s;
      priority case (op)
         OP_OFF: r = cmd_off(s);
         OP_ON:  r = cmd_on(s);
         OP_TOGGLE: begin
            if (s.mode == MODE_ON || s.mode == MODE_TIMED) r = cmd_off(s);
            else r = cmd_on(s);
         end
         OP_TIMED: begin
            if (!(only_on && s.mode != MODE_ON)) begin
               if (s.mode != MODE_DELAYED) r.on_cnt = on_req;
               r.off_cnt = off_req;
               r = reevaluate(r, 1'b0);
            end
         end
         OP_LAMP: begin
            r.lamp = lv;
            if ((s.mode == MODE_ON || s.mode == MODE_TIMED) && !lv) r.mode = MODE_OFF;
            else if ((s.mode == MODE_OFF || s.mode == MODE_DELAYED) && lv) r.mode = MODE_ON;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic chan_state_type tick_update(input chan_state_type s);
      chan_state_type r;
      r = s;
      if (s.armed) begin
         if (s.ticks > 4'd1) begin
            r.ticks = 4'(s.ticks - 4'd1);
         end else begin
            r.armed = 1'b0;
            r.ticks = 4'd0;
            r       = reevaluate(r, 1'b1);
         end
      end
      return r;
   endfunction

endpackage

>>> rtl/core/timed_on_delayed_off_switch.sv
// Timed-on / delayed-off switch bank: top level joining sequencer and state memory.
// Depends on tod_pkg, tod_ram and tod_seq.
// The channel read of an accepted transaction is registered in the state memory, then its result at the output.
// A new transaction is stalled until the last one is done; a tick steps through the
// channels one channel per cycle while the output is not stalled, via the state memory's read and write ports.
// Reset clears per-channel valid bits at once, so all channels read as off; no clearing pass.
module timed_on_delayed_off_switch (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [1:0]  req_channel,
   input  logic        req_only_when_on,
   input  logic [15:0] req_on_time_req,
   input  logic [15:0] req_off_wait_req,
   input  logic        req_lamp_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_out_channel,
   output logic [1:0]  rsp_mode,
   output logic        rsp_lamp_on,
   output logic [15:0] rsp_on_time_left,
   output logic [15:0] rsp_off_wait_left,
   output logic        rsp_ignored,
   output logic        rsp_last
);
   import tod_pkg::*;

   ram_req_type    ram_req;
   chan_state_type rd_data;

   tod_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   tod_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_channel       (req_channel),
      .req_only_when_on  (req_only_when_on),
      .req_on_time_req   (req_on_time_req),
      .req_off_wait_req  (req_off_wait_req),
      .req_lamp_value    (req_lamp_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_mode          (rsp_mode),
      .rsp_lamp_on       (rsp_lamp_on),
      .rsp_on_time_left  (rsp_on_time_left),
      .rsp_off_wait_left (rsp_off_wait_left),
      .rsp_ignored       (rsp_ignored),
      .rsp_last          (rsp_last),
      .ram_req           (ram_req),
      .rd_data           (rd_data)
   );

endmodule

>>> rtl/core/tod_ram.sv
// Per-channel state memory: one read and one write port, registered read.
// Depends on tod_pkg; unwritten entries read as the all-off state.
module tod_ram (
   input  logic                    clock,
   input  logic                    reset,
   input  tod_pkg::ram_req_type    ram_req,
   output tod_pkg::chan_state_type rd_data
);
   import tod_pkg::*;

   chan_state_type ram_ff [CHANNELS];
   logic [CHANNELS-1:0] vld_ff;
   chan_state_type rd_q_ff;
   logic rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) ram_ff[ram_req.wr_idx] <= ram_req.wr_data;
      if (ram_req.rd_en) rd_q_ff <= ram_ff[ram_req.rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ram_req.wr_en) vld_ff[ram_req.wr_idx] <= 1'b1;
         if (ram_req.rd_en) rd_vld_ff <= vld_ff[ram_req.rd_idx];
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : chan_state_type'('0);

endmodule

>>> rtl/core/tod_seq.sv
// Transaction sequencer: reads a channel, applies the command or tick update,
// writes it back and registers the result. Depends on tod_pkg.
module tod_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_opcode,
   input  logic [1:0]              req_channel,
   input  logic                    req_only_when_on,
   input  logic [15:0]             req_on_time_req,
   input  logic [15:0]             req_off_wait_req,
   input  logic                    req_lamp_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_out_channel,
   output logic [1:0]              rsp_mode,
   output logic                    rsp_lamp_on,
   output logic [15:0]             rsp_on_time_left,
   output logic [15:0]             rsp_off_wait_left,
   output logic                    rsp_ignored,
   output logic                    rsp_last,
   output tod_pkg::ram_req_type    ram_req,
   input  tod_pkg::chan_state_type rd_data
);
   import tod_pkg::*;

   seq_state_type  state_ff, state_in;
   opcode_type     op_ff, op_in;
   logic [1:0]     ch_ff, ch_in;
   logic           bad_ff, bad_in;
   logic           only_ff, only_in;
   logic [15:0]    on_req_ff, on_req_in;
   logic [15:0]    off_req_ff, off_req_in;
   logic           lv_ff, lv_in;
   idx_type        idx_ff, idx_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_ch_ff, rsp_ch_in;
   logic [1:0]     rsp_mode_ff, rsp_mode_in;
   logic           rsp_lamp_ff, rsp_lamp_in;
   logic [15:0]    rsp_on_ff, rsp_on_in;
   logic [15:0]    rsp_off_ff, rsp_off_in;
   logic           rsp_ign_ff, rsp_ign_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           accept;
   logic           in_range;
   logic           is_tick;
   logic           out_free;
   logic           item_last;
   chan_state_type upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ch_ff       <= ch_in;
      bad_ff      <= bad_in;
      only_ff     <= only_in;
      on_req_ff   <= on_req_in;
      off_req_ff  <= off_req_in;
      lv_ff       <= lv_in;
      idx_ff      <= idx_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_mode_ff <= rsp_mode_in;
      rsp_lamp_ff <= rsp_lamp_in;
      rsp_on_ff   <= rsp_on_in;
      rsp_off_ff  <= rsp_off_in;
      rsp_ign_ff  <= rsp_ign_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      accept    = req_valid && !req_stall;
      in_range  = (32'(req_channel) < CHANNELS);
      is_tick   = (op_ff == OP_TICK);
      out_free  = !rsp_valid_ff || !rsp_stall;
      item_last = !is_tick || (idx_ff == idx_type'(CHANNELS - 1));

      if (is_tick) upd = tick_update(rd_data);
      else upd = cmd_update(rd_data, op_ff, only_ff, on_req_ff, off_req_ff, lv_ff);

      state_in    = state_ff;
      op_in       = op_ff;
      ch_in       = ch_ff;
      bad_in      = bad_ff;
      only_in     = only_ff;
      on_req_in   = on_req_ff;
      off_req_in  = off_req_ff;
      lv_in       = lv_ff;
      idx_in      = idx_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ch_in    = rsp_ch_ff;
      rsp_mode_in  = rsp_mode_ff;
      rsp_lamp_in  = rsp_lamp_ff;
      rsp_on_in    = rsp_on_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_ign_in   = rsp_ign_ff;
      rsp_last_in  = rsp_last_ff;

      ram_req = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in      = opcode_type'(req_opcode);
               ch_in      = req_channel;
               bad_in     = !in_range;
               only_in    = req_only_when_on;
               on_req_in  = req_on_time_req;
               off_req_in = req_off_wait_req;
               lv_in      = req_lamp_value;
               if (req_opcode == OP_TICK) begin
                  idx_in         = '0;
                  bad_in         = 1'b0;
                  ram_req.rd_en  = 1'b1;
                  ram_req.rd_idx = '0;
                  state_in       = ST_RUN;
               end else if (req_opcode < OP_TICK) begin
                  idx_in         = idx_type'(req_channel);
                  ram_req.rd_en  = in_range;
                  ram_req.rd_idx = idx_type'(req_channel);
                  state_in       = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = item_last;
               if (bad_ff) begin
                  rsp_ch_in   = ch_ff;
                  rsp_mode_in = MODE_OFF;
                  rsp_lamp_in = 1'b0;
                  rsp_on_in   = 16'd0;
                  rsp_off_in  = 16'd0;
                  rsp_ign_in  = 1'b0;
               end else begin
                  rsp_ch_in       = is_tick ? 2'(idx_ff) : ch_ff;
                  rsp_mode_in     = upd.mode;
                  rsp_lamp_in     = upd.lamp;
                  rsp_on_in       = upd.on_cnt;
                  rsp_off_in      = upd.off_cnt;
                  rsp_ign_in      = !is_tick && cmd_ignored(rd_data, op_ff, only_ff);
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_idx  = idx_ff;
                  ram_req.wr_data = upd;
               end
               if (item_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in         = idx_type'(idx_ff + idx_type'(1));
                  ram_req.rd_en  = 1'b1;
                  ram_req.rd_idx = idx_type'(idx_ff + idx_type'(1));
               end
            end
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_channel   = rsp_ch_ff;
   assign rsp_mode          = rsp_mode_ff;
   assign rsp_lamp_on       = rsp_lamp_ff;
   assign rsp_on_time_left  = rsp_on_ff;
   assign rsp_off_wait_left = rsp_off_ff;
   assign rsp_ignored       = rsp_ign_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

>>> rtl/core/tod_checker.sv
// Port-level checks for the switch bank, bound to the top level.
// Depends on tod_pkg and timed_on_delayed_off_switch.
module tod_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [2:0]  req_opcode,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_out_channel,
   input logic [15:0] rsp_on_time_left,
   input logic        rsp_ignored,
   input logic        rsp_last
);
   import tod_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_channel)
                                 && $stable(rsp_on_time_left) && $stable(rsp_last))
      else $error("stalled result transaction changed");

   a_ign_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ignored |-> rsp_last)
      else $error("rejected command result not marked last");

   a_tick_holds_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("input taken while a tick report is still running");

   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode <= 3'(OP_TICK)) |=> req_stall)
      else $error("no busy cycle after a valid transaction");

endmodule

bind timed_on_delayed_off_switch tod_checker u_tod_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_opcode       (req_opcode),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_out_channel  (rsp_out_channel),
   .rsp_on_time_left (rsp_on_time_left),
   .rsp_ignored      (rsp_ignored),
   .rsp_last         (rsp_last)
);

>>> test/tb.sv
// Self-checking testbench for the timed-on / delayed-off switch bank.
// Directed table then random transactions. Table rows are checked against their entries, the rest
// against an in-bench model of the channel timers. Depends on tod_pkg and the RTL top level.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tod_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 355;
   localparam int TAIL_ITEMS   = 60;
   localparam int HOLD_AFTER   = 120;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS  = 10;

   // opcodes with no function
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef struct {
      logic [1:0]  chan;
      mode_type    mode;
      logic        lamp;
      logic [15:0] on_left;
      logic [15:0] off_left;
      logic        ign;
      logic        last;
   } switch_report_type;

   typedef struct {
      logic [2:0]        op;
      logic [1:0]        ch;
      logic              only;
      logic [15:0]       on_t;
      logic [15:0]       off_t;
      logic              lv;
      bit                typed;
      switch_report_type rep;
   } stim_row_type;

   typedef struct {
      mode_type    mode;
      bit          lamp;
      bit [15:0]   on_cnt;
      bit [15:0]   off_cnt;
      bit          armed;
      bit [3:0]    ticks;
   } chan_rec_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_opcode;
   logic [1:0]  req_channel;
   logic        req_only_when_on;
   logic [15:0] req_on_time_req;
   logic [15:0] req_off_wait_req;
   logic        req_lamp_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_out_channel;
   logic [1:0]  rsp_mode;
   logic        rsp_lamp_on;
   logic [15:0] rsp_on_time_left;
   logic [15:0] rsp_off_wait_left;
   logic        rsp_ignored;
   logic        rsp_last;

   chan_rec_type      bank[CHANNELS];
   switch_report_type fresh[CHANNELS];
   int                fresh_n;
   switch_report_type pending_reports[$];
   stim_row_type      directed_rows[$];

   int sent_items   = 0;
   int results_seen = 0;
   int tick_count   = 0;
   int errors       = 0;
   int cycle_cnt    = 0;
   bit quiet_tail   = 1'b0;
   bit hold_done    = 1'b0;

   timed_on_delayed_off_switch uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---- channel model ----

   function automatic void settle(int ch, bit wake);
      bit [15:0] on_t;
      bit [15:0] off_t;
      bit [3:0]  nxt;
      on_t  = bank[ch].on_cnt;
      off_t = bank[ch].off_cnt;
      nxt   = WAKE_TICKS;
      case (bank[ch].mode)
         MODE_ON: begin
            if (on_t != 16'd0) bank[ch].mode = MODE_TIMED;
            else if (off_t != 16'd0) bank[ch].mode = MODE_DELAYED;
         end
         MODE_OFF: begin
            if (on_t != 16'd0) begin
               bank[ch].lamp = 1'b1;
               bank[ch].mode = MODE_TIMED;
            end else if (off_t != 16'd0) begin
               bank[ch].mode = MODE_DELAYED;
            end
         end
         MODE_TIMED: begin
            if (wake) on_t = (on_t >= STEP) ? on_t - STEP : 16'd0;
            bank[ch].on_cnt = on_t;
            if (on_t == 16'd0) begin
               bank[ch].lamp = 1'b0;
               if (off_t != 16'd0) begin
                  bank[ch].mode = MODE_DELAYED;
               end else begin
                  bank[ch].mode = MODE_OFF;
                  nxt = 4'd0;
               end
            end else if (on_t < STEP) begin
               nxt = on_t[3:0];
            end
         end
         default: begin
            if (wake) off_t = (off_t >= STEP) ? off_t - STEP : 16'd0;
            bank[ch].off_cnt = off_t;
            if (off_t == 16'd0) begin
               bank[ch].mode = MODE_OFF;
               nxt = 4'd0;
            end else if (off_t < STEP) begin
               nxt = off_t[3:0];
            end
         end
      endcase
      if (nxt != 4'd0) begin
         bank[ch].armed = 1'b1;
         bank[ch].ticks = nxt;
      end
   endfunction

   function automatic void switch_off(int ch);
      case (bank[ch].mode)
         MODE_ON: begin
            bank[ch].mode = MODE_OFF;
            bank[ch].lamp = 1'b0;
         end
         MODE_TIMED: begin
            bank[ch].on_cnt = 16'd0;
            bank[ch].armed  = 1'b0;
            bank[ch].ticks  = 4'd0;
            settle(ch, 1'b0);
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void switch_on(int ch);
      if (bank[ch].mode == MODE_OFF) begin
         bank[ch].lamp = 1'b1;
      end else if (bank[ch].mode != MODE_ON) begin
         bank[ch].armed   = 1'b0;
         bank[ch].ticks   = 4'd0;
         bank[ch].on_cnt  = 16'd0;
         bank[ch].off_cnt = 16'd0;
         if (bank[ch].mode == MODE_DELAYED) bank[ch].lamp = 1'b1;
      end
      bank[ch].mode = MODE_ON;
   endfunction

   function automatic switch_report_type snapshot(int ch, bit ign, bit last);
      switch_report_type r;
      r.chan     = 2'(ch);
      r.mode     = bank[ch].mode;
      r.lamp     = bank[ch].lamp;
      r.on_left  = bank[ch].on_cnt;
      r.off_left = bank[ch].off_cnt;
      r.ign      = ign;
      r.last     = last;
      return r;
   endfunction

   // Fills fresh[0 .. fresh_n-1] with the reports one transaction produces.
   function automatic void predict_item(stim_row_type r);
      int       ch;
      bit       ign;
      mode_type m;
      fresh_n = 0;
      ch      = r.ch;
      ign     = 1'b0;
      if (r.op == OP_TICK) begin
         tick_count++;
         for (int i = 0; i < CHANNELS; i++) begin
            if (bank[i].armed) begin
               if (bank[i].ticks > 4'd1) begin
                  bank[i].ticks = bank[i].ticks - 4'd1;
               end else begin
                  bank[i].armed = 1'b0;
                  bank[i].ticks = 4'd0;
                  settle(i, 1'b1);
               end
            end
         end
         for (int i = 0; i < CHANNELS; i++) fresh[i] = snapshot(i, 1'b0, i == CHANNELS - 1);
         fresh_n = CHANNELS;
         return;
      end
      if (r.op > OP_TICK) return;
      m = bank[ch].mode;
      case (r.op)
         OP_OFF: switch_off(ch);
         OP_ON:  switch_on(ch);
         OP_TOGGLE: begin
            if (m == MODE_ON || m == MODE_TIMED) switch_off(ch);
            else switch_on(ch);
         end
         OP_TIMED: begin
            if (r.only && m != MODE_ON) begin
               ign = 1'b1;
            end else begin
               if (m != MODE_DELAYED) bank[ch].on_cnt = r.on_t;
               bank[ch].off_cnt = r.off_t;
               settle(ch, 1'b0);
            end
         end
         default: begin
            bank[ch].lamp = r.lv;
            if ((m == MODE_ON || m == MODE_TIMED) && !r.lv) bank[ch].mode = MODE_OFF;
            else if ((m == MODE_OFF || m == MODE_DELAYED) && r.lv) bank[ch].mode = MODE_ON;
         end
      endcase
      fresh[0] = snapshot(ch, ign, 1'b1);
      fresh_n  = 1;
   endfunction

   // ---- stimulus ----

   function automatic void add_row(logic [2:0] op, logic [1:0] ch, logic only,
                                   logic [15:0] on_t, logic [15:0] off_t, logic lv,
                                   bit typed, mode_type mode, logic lamp,
                                   logic [15:0] on_left, logic [15:0] off_left, logic ign);
      stim_row_type r;
      r.op           = op;
      r.ch           = ch;
      r.only         = only;
      r.on_t         = on_t;
      r.off_t        = off_t;
      r.lv           = lv;
      r.typed        = typed;
      r.rep.chan     = ch;
      r.rep.mode     = mode;
      r.rep.lamp     = lamp;
      r.rep.on_left  = on_left;
      r.rep.off_left = off_left;
      r.rep.ign      = ign;
      r.rep.last     = 1'b1;
      directed_rows.push_back(r);
   endfunction

   function automatic logic [15:0] pick_tenths();
      int k;
      k = $urandom_range(0, 9);
      if (k <= 5) return 16'($urandom_range(0, 40));
      if (k == 7) return 16'($urandom_range(0, 200));
      if (k == 6) begin
         case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return 16'd9;
            2:       return 16'd10;
            3:       return 16'd11;
            default: return 16'hFFFF;
         endcase
      end
      return 16'($urandom);
   endfunction

   task automatic offer(input stim_row_type r);
      int gap;
      gap = 0;
      if (!quiet_tail && (sent_items % 64) >= 16 && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 11);
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_opcode       <= r.op;
      req_channel      <= r.ch;
      req_only_when_on <= r.only;
      req_on_time_req  <= r.on_t;
      req_off_wait_req <= r.off_t;
      req_lamp_value   <= r.lv;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      predict_item(r);
      if (r.typed && fresh_n == 1) begin
         pending_reports.push_back(r.rep);
      end else begin
         for (int i = 0; i < fresh_n; i++) pending_reports.push_back(fresh[i]);
      end
      sent_items++;
   endtask

   initial begin : stimulus
      stim_row_type r;
      int           pick;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = OP_OFF;
      req_channel      = 2'd0;
      req_only_when_on = 1'b0;
      req_on_time_req  = 16'd0;
      req_off_wait_req = 16'd0;
      req_lamp_value   = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
         bank[i].mode    = MODE_OFF;
         bank[i].lamp    = 1'b0;
         bank[i].on_cnt  = 16'd0;
         bank[i].off_cnt = 16'd0;
         bank[i].armed   = 1'b0;
         bank[i].ticks   = 4'd0;
      end

      add_row(OP_ON,     2'd0, 1'b0, 16'd0,   16'd0,   1'b0,
              1'b1, MODE_ON,      1'b1, 16'd0,   16'd0,   1'b0);
      add_row(OP_TIMED,  2'd1, 1'b1, 16'd50,  16'd20,  1'b0,
              1'b1, MODE_OFF,     1'b0, 16'd0,   16'd0,   1'b1);
      add_row(OP_TIMED,  2'd1, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0,
              1'b1, MODE_TIMED,   1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
      add_row(OP_TIMED,  2'd0, 1'b1, 16'd5,   16'd3,   1'b0,
              1'b1, MODE_TIMED,   1'b1, 16'd5,   16'd3,   1'b0);
      add_row(OP_TOGGLE, 2'd2, 1'b0, 16'd0,   16'd0,   1'b0,
              1'b1, MODE_ON,      1'b1, 16'd0,   16'd0,   1'b0);
      add_row(OP_TOGGLE, 2'd2, 1'b0, 16'd0,   16'd0,   1'b0,
              1'b1, MODE_OFF,     1'b0, 16'd0,   16'd0,   1'b0);
      add_row(OP_LAMP,   2'd3, 1'b0, 16'd0,   16'd0,   1'b1,
              1'b1, MODE_ON,      1'b1, 16'd0,   16'd0,   1'b0);
      add_row(OP_LAMP,   2'd3, 1'b0, 16'd0,   16'd0,   1'b0,
              1'b1, MODE_OFF,     1'b0, 16'd0,   16'd0,   1'b0);
      add_row(OP_SPARE_6, 2'd0, 1'b0, 16'd0,  16'd0,   1'b0,
              1'b0, MODE_OFF,     1'b0, 16'd0,   16'd0,   1'b0);
      add_row(OP_SPARE_7, 2'd3, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1,
              1'b0, MODE_OFF,     1'b0, 16'd0,   16'd0,   1'b0);
      add_row(OP_TIMED,  2'd2, 1'b0, 16'd0,   16'd25,  1'b0,
              1'b1, MODE_DELAYED, 1'b0, 16'd0,   16'd25,  1'b0);
      add_row(OP_TIMED,  2'd2, 1'b0, 16'd100, 16'd7,   1'b0,
              1'b1, MODE_DELAYED, 1'b0, 16'd0,   16'd7,   1'b0);
      add_row(OP_OFF,    2'd3, 1'b0, 16'd0,   16'd0,   1'b0,
              1'b1, MODE_OFF,     1'b0, 16'd0,   16'd0,   1'b0);
      add_row(OP_ON,     2'd1, 1'b0, 16'd0,   16'd0,   1'b0,
              1'b1, MODE_ON,      1'b1, 16'd0,   16'd0,   1'b0);
      add_row(OP_TIMED,  2'd1, 1'b1, 16'd0,   16'd12,  1'b0,
              1'b1, MODE_DELAYED, 1'b1, 16'd0,   16'd12,  1'b0);
      // ten ticks: short remainders, expiry into delayed-off and into off
      repeat (10)
         add_row(OP_TICK, 2'd0, 1'b0, 16'd0, 16'd0, 1'b0,
                 1'b0, MODE_OFF, 1'b0, 16'd0, 16'd0, 1'b0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) offer(directed_rows[i]);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet_tail = (n >= RANDOM_ITEMS - TAIL_ITEMS);
         pick    = $urandom_range(0, 99);
         r.typed = 1'b0;
         r.rep   = fresh[0];
         if (pick < 40)      r.op = OP_TICK;
         else if (pick < 48) r.op = OP_OFF;
         else if (pick < 56) r.op = OP_ON;
         else if (pick < 64) r.op = OP_TOGGLE;
         else if (pick < 84) r.op = OP_TIMED;
         else if (pick < 96) r.op = OP_LAMP;
         else                r.op = ($urandom_range(0, 1) != 0) ? OP_SPARE_7 : OP_SPARE_6;
         r.ch    = 2'($urandom_range(0, 3));
         r.only  = 1'($urandom_range(0, 1));
         r.on_t  = pick_tenths();
         r.off_t = pick_tenths();
         r.lv    = 1'($urandom_range(0, 1));
         offer(r);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d transactions in (%0d ticks) and %0d results out,",
               sent_items, tick_count, results_seen);
      $display("with idle bursts on both sides and one %0d-cycle receiver hold; %0d errors.",
               HOLD_CYCLES, errors);
      if (errors == 0 && pending_reports.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // ---- receiver side ----

   initial begin : receiver
      int burst;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && sent_items >= HOLD_AFTER) begin
            // long hold so the block backs up and stalls its input
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet_tail && (cycle_cnt % 400) >= 100 && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 11);
            rsp_stall <= 1'b1;
            repeat (burst) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_results
      switch_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_reports.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected result: ch=%0d mode=%0d lamp=%0d on=%0d off=%0d",
                        rsp_out_channel, rsp_mode, rsp_lamp_on, rsp_on_time_left,
                        rsp_off_wait_left);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_out_channel !== want.chan || rsp_mode !== want.mode ||
                rsp_lamp_on !== want.lamp || rsp_on_time_left !== want.on_left ||
                rsp_off_wait_left !== want.off_left || rsp_ignored !== want.ign ||
                rsp_last !== want.last) begin
               errors++;
               if (errors <= MAX_REPORTS) begin
                  $display("mismatch on result %0d:", results_seen);
                  $display("  got  ch=%0d mode=%0d lamp=%0d on=%0d off=%0d ign=%0d last=%0d",
                           rsp_out_channel, rsp_mode, rsp_lamp_on, rsp_on_time_left,
                           rsp_off_wait_left, rsp_ignored, rsp_last);
                  $display("  want ch=%0d mode=%0d lamp=%0d on=%0d off=%0d ign=%0d last=%0d",
                           want.chan, want.mode, want.lamp, want.on_left, want.off_left,
                           want.ign, want.last);
               end
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
